FILE: sv/whe_pkg.sv
// Shared types, widths and codes for the weighted histogram engine.
// Depends on nothing; every other file imports it.
`default_nettype none
package whe_pkg;

  localparam int MAX_BINS_DEF = 256;

  localparam int X_W        = 32;
  localparam int W_W        = 16;
  localparam int IDX_W      = 9;
  localparam int SUM_W      = 48;
  localparam int CNT_W      = 32;
  localparam int ST_W       = 2;
  localparam int CMD_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int BND_W       = 48;
  localparam int DIST_W      = 33;
  localparam int NUM_W       = 57;
  localparam int QUO_W       = 32;
  localparam int VAL_W       = 25;
  localparam int SHARE_STEPS = 25;
  localparam int UNI_STEPS   = 32;
  localparam int STEP_W      = 6;
  localparam int QDEPTH      = 2;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [30:0]      ONE_Q16 = 31'd65536;

  localparam logic [CMD_W-1:0] CMD_FILL_PT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FILL_RG = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_BIN_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_EDGE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT = 2'd3;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_SKIP = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    OP_FILL_PT, OP_FILL_RG, OP_READ, OP_CLEAR, OP_APPEND, OP_NOP
  } op_t;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [X_W-1:0]   x;
    logic signed [X_W-1:0]   x_upper;
    logic [W_W-1:0]          weight;
    logic [IDX_W-1:0]        bin_index;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [SUM_W-1:0] bin_value;
    logic [IDX_W-1:0] found_bin;
    logic [CNT_W-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic                  bin_mode;
    logic signed [X_W-1:0] low_edge;
    logic [30:0]           bin_width;
    logic [8:0]            bin_count;
  } cfg_t;

  typedef struct packed {
    op_t                   op;
    logic signed [X_W-1:0] lo;
    logic signed [X_W-1:0] hi;
    logic [DIST_W-1:0]     span;
    logic signed [X_W:0]   d_lo;
    logic signed [X_W:0]   d_hi;
    logic [W_W-1:0]        weight;
    logic [IDX_W-1:0]      bin_index;
  } job_t;

  typedef struct packed {
    logic              start;
    logic [DIST_W-1:0] rem;
    logic [QUO_W-1:0]  bits;
    logic [STEP_W-1:0] steps;
    logic [DIST_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: sv/whe_front.sv
// Front end: takes input beats, decodes the command, orders range ends
// and forms offsets for the back end. Depends on whe_pkg.
`default_nettype none
module whe_front import whe_pkg::*; (
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  cfg_t     cfg,
  input  logic     q_full,
  output logic     q_push,
  output job_t     q_job
);

  logic signed [X_W-1:0] lo;
  logic signed [X_W-1:0] hi;
  op_t                   op;

  always_comb begin
    case (in_data.cmd)
      CMD_FILL_PT: op = OP_FILL_PT;
      CMD_FILL_RG: op = OP_FILL_RG;
      CMD_READ:    op = OP_READ;
      CMD_CLEAR:   op = OP_CLEAR;
      CMD_APPEND:  op = OP_APPEND;
      default:     op = OP_NOP;
    endcase
    if (op == OP_FILL_RG && in_data.x_upper < in_data.x) begin
      lo = in_data.x_upper;
      hi = in_data.x;
    end else if (op == OP_FILL_RG) begin
      lo = in_data.x;
      hi = in_data.x_upper;
    end else begin
      lo = in_data.x;
      hi = in_data.x;
    end
  end

  always_comb begin
    q_job.op        = op;
    q_job.lo        = lo;
    q_job.hi        = hi;
    q_job.span      = DIST_W'($signed({hi[X_W-1], hi}) - $signed({lo[X_W-1], lo}));
    q_job.d_lo      = $signed({lo[X_W-1], lo})
                      - $signed({cfg.low_edge[X_W-1], cfg.low_edge});
    q_job.d_hi      = $signed({hi[X_W-1], hi})
                      - $signed({cfg.low_edge[X_W-1], cfg.low_edge});
    q_job.weight    = in_data.weight;
    q_job.bin_index = in_data.bin_index;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

endmodule
`default_nettype wire

FILE: sv/whe_queue.sv
// Short job queue between the front end and the back end.
// Depends on whe_pkg for the job type and depth.
`default_nettype none
module whe_queue import whe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  job_t          slots_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  assign pop_job = slots_r[rd_ptr_r];
  assign full    = (cnt_r == CW'(QDEPTH));
  assign empty   = (cnt_r == '0);

endmodule
`default_nettype wire

FILE: sv/whe_div.sv
// Restoring divider, one quotient bit per cycle, shared by bin lookup and
// range shares. Depends on whe_pkg for the request and response types.
`default_nettype none
module whe_div import whe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIST_W-1:0] rem_r;
  logic [DIST_W-1:0] rem_nxt;
  logic [DIST_W-1:0] div_r;
  logic [QUO_W-1:0]  bits_r;
  logic [QUO_W-1:0]  q_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIST_W:0]   trial;
  logic              ge;

  always_comb begin
    trial   = {rem_r, bits_r[QUO_W-1]} - {1'b0, div_r};
    ge      = ~trial[DIST_W];
    rem_nxt = ge ? trial[DIST_W-1:0] : {rem_r[DIST_W-2:0], bits_r[QUO_W-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.rem;
      bits_r <= req.bits;
      div_r  <= req.divisor;
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      bits_r <= {bits_r[QUO_W-2:0], 1'b0};
      q_r    <= {q_r[QUO_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule
`default_nettype wire

FILE: sv/whe_back.sv
// Back end: sequencer that looks up bins, walks range fills, owns the bin
// sums and edge table, and holds the output register. Depends on whe_pkg.
`default_nettype none
module whe_back import whe_pkg::*; #(
  parameter int MAX_BINS = MAX_BINS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_empty,
  input  job_t      q_job,
  output logic      q_pop,
  output div_req_t  div_req,
  input  div_rsp_t  div_rsp,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int NSLOT  = MAX_BINS + 2;
  localparam int NEDGE  = MAX_BINS + 1;
  localparam int SW     = $clog2(NSLOT);
  localparam int EAW    = $clog2(NEDGE);
  localparam int CMPW   = ((SW > IDX_W) ? SW : IDX_W) + 1;
  localparam int PROD_W = SW + 31;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_READ_W, S_FIND, S_DIVW, S_SRCH_A, S_SRCH_C, S_FOUND,
    S_SUM_RD, S_SUM_WR, S_W_FETCH, S_W_LEN, S_W_MUL, S_W_DIV, S_W_DIVW, S_RESULT
  } state_t;

  state_t                  state_r;
  job_t                    job_r;
  logic                    find_hi_r;
  logic                    walking_r;
  logic [SW-1:0]           slot_r;
  logic [SW-1:0]           found_r;
  logic [SW-1:0]           sl_r;
  logic [SW-1:0]           su_r;
  logic [SW-1:0]           walk_s_r;
  logic [SW-1:0]           srch_lo_r;
  logic [SW-1:0]           srch_hi_r;
  logic [SW-1:0]           mid_r;
  logic [SW-1:0]           edges_r;
  logic signed [X_W-1:0]   first_edge_r;
  logic signed [X_W-1:0]   last_edge_r;
  logic signed [BND_W-1:0] b_prev_r;
  logic [PROD_W-1:0]       prod_r;
  logic [DIST_W-1:0]       len_r;
  logic [NUM_W-1:0]        num_r;
  logic [VAL_W-1:0]        val_r;
  logic [CNT_W-1:0]        fill_total_r;
  logic [ST_W-1:0]         status_r;
  logic [SUM_W-1:0]        value_r;
  logic [NSLOT-1:0]        valid_r;
  div_req_t                div_req_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  logic [SUM_W-1:0]        sum_mem [NSLOT];
  logic [SUM_W-1:0]        sum_rd_r;
  logic                    sum_vld_r;
  logic signed [X_W-1:0]   edge_mem [NEDGE];
  logic signed [X_W-1:0]   edge_rd_r;

  logic [SW-1:0]           n_bins;
  logic [SW-1:0]           n_plus1;
  logic [SW-1:0]           read_slot;
  logic [SW:0]             srch_sum;
  logic [SW-1:0]           mid_nxt;
  logic [30:0]             uni_wid;
  logic [30:0]             bnd_step;
  logic                    tbl_m2;
  logic signed [BND_W-1:0] bnd_base;
  logic signed [BND_W-1:0] bnd;
  logic signed [BND_W-1:0] hi_side;
  logic signed [BND_W-1:0] lo_side;
  logic signed [X_W-1:0]   key;
  logic signed [X_W:0]     dkey;
  logic signed [X_W:0]     upper_edge;
  logic [PROD_W-1:0]       prod_full;
  logic [W_W+DIST_W-1:0]   wl_prod;
  logic [SUM_W-1:0]        sum_old;
  logic [SUM_W:0]          sum_add;
  logic [SUM_W-1:0]        sum_wdata;
  logic                    sum_we;
  logic [SW-1:0]           sum_raddr;
  logic                    append_ok;
  logic                    edge_we;
  logic [EAW-1:0]          edge_raddr;

  always_comb begin
    if (!cfg.bin_mode) begin
      if (cfg.bin_count == '0) begin
        n_bins = SW'(1);
      end else if (CMPW'(cfg.bin_count) > CMPW'(MAX_BINS)) begin
        n_bins = SW'(MAX_BINS);
      end else begin
        n_bins = SW'(cfg.bin_count);
      end
    end else if (edges_r >= SW'(2)) begin
      n_bins = edges_r - 1'b1;
    end else begin
      n_bins = edges_r;
    end
    n_plus1 = n_bins + 1'b1;

    if (CMPW'(job_r.bin_index) > CMPW'(n_plus1)) begin
      read_slot = n_plus1;
    end else begin
      read_slot = SW'(job_r.bin_index);
    end

    srch_sum = {1'b0, srch_lo_r} + {1'b0, srch_hi_r};
    mid_nxt  = srch_sum[SW:1];

    uni_wid  = (cfg.bin_width == '0) ? 31'd1 : cfg.bin_width;
    tbl_m2   = cfg.bin_mode && (edges_r >= SW'(2));
    bnd_base = cfg.bin_mode ? BND_W'(first_edge_r) : BND_W'(cfg.low_edge);
    bnd_step = cfg.bin_mode ? ONE_Q16 : uni_wid;

    key  = find_hi_r ? job_r.hi : job_r.lo;
    dkey = find_hi_r ? job_r.d_hi : job_r.d_lo;
    if (edges_r == SW'(1)) begin
      upper_edge = (X_W+1)'(first_edge_r) + $signed((X_W+1)'(ONE_Q16));
    end else begin
      upper_edge = (X_W+1)'(last_edge_r);
    end

    prod_full = walk_s_r * bnd_step;
    if (tbl_m2) begin
      bnd = BND_W'(edge_rd_r);
    end else begin
      bnd = bnd_base + BND_W'($signed({1'b0, prod_r}));
    end
    hi_side = (walk_s_r == su_r) ? BND_W'(job_r.hi) : bnd;
    lo_side = (walk_s_r == sl_r) ? BND_W'(job_r.lo) : b_prev_r;

    wl_prod = job_r.weight * len_r;

    sum_old   = sum_vld_r ? sum_rd_r : '0;
    sum_add   = {1'b0, sum_old} + (SUM_W+1)'(val_r);
    sum_wdata = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    sum_we    = (state_r == S_SUM_WR);
    sum_raddr = (state_r == S_DECODE) ? read_slot : slot_r;

    append_ok = (CMPW'(edges_r) < CMPW'(NEDGE))
                && ((edges_r == '0) || (job_r.lo > last_edge_r));
    edge_we    = (state_r == S_DECODE) && (job_r.op == OP_APPEND) && append_ok;
    edge_raddr = (state_r == S_SRCH_A) ? mid_nxt[EAW-1:0] : walk_s_r[EAW-1:0];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[slot_r] <= sum_wdata;
    end
    sum_rd_r  <= sum_mem[sum_raddr];
    sum_vld_r <= valid_r[sum_raddr];
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edges_r[EAW-1:0]] <= job_r.lo;
    end
    edge_rd_r <= edge_mem[edge_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      edges_r         <= '0;
      fill_total_r    <= '0;
      valid_r         <= '0;
      out_valid_r     <= 1'b0;
      div_req_r.start <= 1'b0;
    end else begin
      div_req_r.start <= ((state_r == S_FIND) && !cfg.bin_mode && !dkey[X_W])
                         || (state_r == S_W_DIV);
      if (out_valid_r && !out_stall && state_r != S_RESULT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            job_r   <= q_job;
            state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (job_r.op == OP_APPEND && CMPW'(edges_r) >= CMPW'(NEDGE)) begin
            status_r <= ST_FULL;
          end else if (job_r.op == OP_APPEND && !append_ok) begin
            status_r <= ST_SKIP;
          end else begin
            status_r <= ST_OK;
          end
          value_r   <= '0;
          found_r   <= '0;
          find_hi_r <= 1'b0;
          walking_r <= 1'b0;
          case (job_r.op)
            OP_FILL_PT, OP_FILL_RG: state_r <= S_FIND;
            OP_READ:                state_r <= S_READ_W;
            OP_CLEAR: begin
              valid_r <= '0;
              state_r <= S_RESULT;
            end
            OP_APPEND: begin
              if (append_ok) begin
                edges_r     <= edges_r + 1'b1;
                last_edge_r <= job_r.lo;
                if (edges_r == '0) begin
                  first_edge_r <= job_r.lo;
                end
              end
              state_r <= S_RESULT;
            end
            default: state_r <= S_RESULT;
          endcase
        end
        S_READ_W: begin
          value_r <= sum_old;
          state_r <= S_RESULT;
        end
        S_FIND: begin
          if (!cfg.bin_mode) begin
            if (dkey[X_W]) begin
              slot_r  <= '0;
              state_r <= S_FOUND;
            end else begin
              div_req_r.rem     <= '0;
              div_req_r.bits    <= dkey[X_W-1:0];
              div_req_r.steps   <= STEP_W'(UNI_STEPS);
              div_req_r.divisor <= DIST_W'(uni_wid);
              state_r           <= S_DIVW;
            end
          end else if (n_bins == '0 || key < first_edge_r) begin
            slot_r  <= '0;
            state_r <= S_FOUND;
          end else if ((X_W+1)'(key) >= upper_edge) begin
            slot_r  <= n_plus1;
            state_r <= S_FOUND;
          end else begin
            srch_lo_r <= '0;
            srch_hi_r <= n_bins;
            state_r   <= S_SRCH_A;
          end
        end
        S_DIVW: begin
          if (div_rsp.done) begin
            if (div_rsp.quot >= QUO_W'(n_bins)) begin
              slot_r <= n_plus1;
            end else begin
              slot_r <= div_rsp.quot[SW-1:0] + 1'b1;
            end
            state_r <= S_FOUND;
          end
        end
        S_SRCH_A: begin
          if ((srch_hi_r - srch_lo_r) > SW'(1)) begin
            mid_r   <= mid_nxt;
            state_r <= S_SRCH_C;
          end else begin
            slot_r  <= srch_lo_r + 1'b1;
            state_r <= S_FOUND;
          end
        end
        S_SRCH_C: begin
          if (edge_rd_r <= key) begin
            srch_lo_r <= mid_r;
          end else begin
            srch_hi_r <= mid_r;
          end
          state_r <= S_SRCH_A;
        end
        S_FOUND: begin
          if (job_r.op == OP_FILL_RG && !find_hi_r) begin
            sl_r      <= slot_r;
            found_r   <= slot_r;
            find_hi_r <= 1'b1;
            state_r   <= S_FIND;
          end else if (job_r.op == OP_FILL_RG && slot_r != sl_r) begin
            su_r      <= slot_r;
            walk_s_r  <= sl_r;
            walking_r <= 1'b1;
            state_r   <= S_W_FETCH;
          end else begin
            if (job_r.op == OP_FILL_PT) begin
              found_r <= slot_r;
            end
            val_r   <= VAL_W'({job_r.weight, 8'b0});
            state_r <= S_SUM_RD;
          end
        end
        S_SUM_RD: state_r <= S_SUM_WR;
        S_SUM_WR: begin
          valid_r[slot_r] <= 1'b1;
          if (walking_r && walk_s_r != su_r) begin
            walk_s_r <= walk_s_r + 1'b1;
            state_r  <= S_W_FETCH;
          end else begin
            if (fill_total_r != CNT_MAX) begin
              fill_total_r <= fill_total_r + 1'b1;
            end
            state_r <= S_RESULT;
          end
        end
        S_W_FETCH: begin
          prod_r  <= prod_full;
          state_r <= S_W_LEN;
        end
        S_W_LEN: begin
          len_r <= DIST_W'(hi_side - lo_side);
          if (walk_s_r != su_r) begin
            b_prev_r <= bnd;
          end
          state_r <= S_W_MUL;
        end
        S_W_MUL: begin
          num_r   <= {wl_prod, 8'b0};
          state_r <= S_W_DIV;
        end
        S_W_DIV: begin
          div_req_r.rem     <= DIST_W'(num_r[NUM_W-1:SHARE_STEPS]);
          div_req_r.bits    <= {num_r[SHARE_STEPS-1:0], (QUO_W-SHARE_STEPS)'(0)};
          div_req_r.steps   <= STEP_W'(SHARE_STEPS);
          div_req_r.divisor <= job_r.span;
          state_r           <= S_W_DIVW;
        end
        S_W_DIVW: begin
          if (div_rsp.done) begin
            val_r   <= div_rsp.quot[VAL_W-1:0];
            slot_r  <= walk_s_r;
            state_r <= S_SUM_RD;
          end
        end
        S_RESULT: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r.status      <= status_r;
            out_data_r.bin_value   <= value_r;
            out_data_r.found_bin   <= IDX_W'(found_r);
            out_data_r.entry_count <= fill_total_r;
            out_valid_r            <= 1'b1;
            state_r                <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign div_req   = div_req_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

FILE: sv/weighted_histogram_engine.sv
// Top level of the weighted histogram engine: configuration registers and
// the front end, job queue, divider and back end. Depends on whe_pkg.
//
//   port group  dir  handshake             beat
//   in_         in   in_valid / in_stall   in_data (in_item_t)
//   out_        out  out_valid / out_stall out_data (out_item_t)
//   cfg_        in   cfg_we                cfg_index, cfg_wdata
//
// Uniform point fill uses the 32-step divider for its bin lookup; table
// point fill uses a binary search over the edge table. Range fill takes
// two lookups plus one 25-step share divide per covered bin when it spans
// more than one bin. Reset is synchronous; bin sums read as zero through
// per-bin valid bits, so there is no clearing pass.
// A two-beat queue and the output register let each side stall on its own.
`default_nettype none
module weighted_histogram_engine import whe_pkg::*; #(
  parameter int MAX_BINS = MAX_BINS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t     cfg_r;
  logic     q_full;
  logic     q_push;
  job_t     push_job;
  logic     q_pop;
  job_t     pop_job;
  logic     q_empty;
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bin_mode  <= 1'b0;
      cfg_r.low_edge  <= '0;
      cfg_r.bin_width <= ONE_Q16;
      cfg_r.bin_count <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BIN_MODE:  cfg_r.bin_mode  <= cfg_wdata[0];
        CFG_LOW_EDGE:  cfg_r.low_edge  <= $signed(cfg_wdata[X_W-1:0]);
        CFG_BIN_WIDTH: cfg_r.bin_width <= cfg_wdata[30:0];
        CFG_BIN_COUNT: cfg_r.bin_count <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  whe_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  whe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  whe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  whe_back #(
    .MAX_BINS (MAX_BINS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for weighted_histogram_engine: directed and random beats
// checked against an in-bench model of the histogram, with random idling.
// Depends on whe_pkg and the engine RTL.
`default_nettype none
module tb;
  import whe_pkg::*;

  localparam int NSLOT = MAX_BINS_DEF + 2;
  localparam int NEDGE = MAX_BINS_DEF + 1;
  localparam longint XMIN = -64'sd2147483648;
  localparam longint XMAX = 64'sd2147483647;
  localparam longint unsigned SUM_TOP = 64'hFFFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 60000000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  in_item_t in_data;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  weighted_histogram_engine DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // histogram state mirrored by the bench
  longint unsigned sums[NSLOT];
  longint edges[NEDGE];
  int unsigned n_edges;
  longint unsigned fills;
  bit mode_tab;
  longint low_e;
  longint unsigned width_r;
  int unsigned count_r;

  out_item_t pending_results[$];
  int unsigned in_beats, out_beats, cycles;
  bit failed, calm;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned bins_in_use();
    int unsigned c;
    if (!mode_tab) begin
      c = count_r;
      if (c < 1) c = 1;
      if (c > MAX_BINS_DEF) c = MAX_BINS_DEF;
      return c;
    end
    return n_edges >= 2 ? n_edges - 1 : n_edges;
  endfunction

  function automatic longint uni_w();
    return width_r == 0 ? 1 : longint'(width_r);
  endfunction

  function automatic longint bin_lo(int unsigned s);
    if (!mode_tab) return low_e + longint'(s - 1) * uni_w();
    return edges[(s - 1) % NEDGE];
  endfunction

  function automatic longint bin_hi(int unsigned s);
    if (!mode_tab) return low_e + longint'(s) * uni_w();
    if (n_edges == 1) return edges[0] + 65536;
    return edges[s % NEDGE];
  endfunction

  function automatic int unsigned locate_bin(longint x);
    int unsigned n, lo, hi, mid;
    longint d;
    n = bins_in_use();
    if (!mode_tab) begin
      d = x - low_e;
      if (d < 0) return 0;
      d = d / uni_w();
      return d >= longint'(n) ? n + 1 : int'(d) + 1;
    end
    if (n == 0) return 0;
    if (x < bin_lo(1)) return 0;
    if (x >= bin_hi(n)) return n + 1;
    lo = 0;
    hi = n;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (edges[mid % NEDGE] <= x) lo = mid;
      else hi = mid;
    end
    return lo + 1;
  endfunction

  function automatic void accumulate(int unsigned s, longint unsigned v);
    longint unsigned t;
    t = sums[s % NSLOT] + v;
    sums[s % NSLOT] = (t > SUM_TOP || t < v) ? SUM_TOP : t;
  endfunction

  function automatic longint unsigned portion(longint unsigned w, longint len, longint span);
    return (w * 256 * longint'(len)) / longint'(span);
  endfunction

  function automatic out_item_t histogram_step(in_item_t it);
    out_item_t r;
    longint x, xu, lo, hi, span;
    longint unsigned w;
    int unsigned n, sl, su, s, idx;
    r = '0;
    x = longint'($signed(it.x));
    xu = longint'($signed(it.x_upper));
    w = it.weight;
    idx = it.bin_index;
    n = bins_in_use();
    case (it.cmd)
      CMD_FILL_PT: begin
        s = locate_bin(x);
        accumulate(s, w << 8);
        r.found_bin = IDX_W'(s);
        if (fills != 64'hFFFF_FFFF) fills++;
      end
      CMD_FILL_RG: begin
        lo = x;
        hi = xu;
        if (hi < lo) begin
          lo = xu;
          hi = x;
        end
        sl = locate_bin(lo);
        su = locate_bin(hi);
        r.found_bin = IDX_W'(sl);
        if (sl == su) begin
          accumulate(sl, w << 8);
        end else begin
          span = hi - lo;
          accumulate(sl, portion(w, (sl == 0) ? bin_lo(1) - lo : bin_hi(sl) - lo, span));
          accumulate(su, portion(w, hi - ((su == n + 1) ? bin_hi(n) : bin_lo(su)), span));
          for (s = sl + 1; s < su; s++)
            accumulate(s, portion(w, bin_hi(s) - bin_lo(s), span));
        end
        if (fills != 64'hFFFF_FFFF) fills++;
      end
      CMD_READ: begin
        s = idx > n + 1 ? n + 1 : idx;
        r.bin_value = sums[s % NSLOT];
      end
      CMD_CLEAR: begin
        foreach (sums[i]) sums[i] = 0;
      end
      CMD_APPEND: begin
        if (n_edges >= NEDGE) r.status = ST_FULL;
        else if (n_edges > 0 && x <= edges[(n_edges - 1) % NEDGE]) r.status = ST_SKIP;
        else begin
          edges[n_edges] = x;
          n_edges++;
        end
      end
      default: ;
    endcase
    r.entry_count = fills[31:0];
    return r;
  endfunction

  // accept and score beats at the rising edge
  always @(posedge clk) begin
    out_item_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else if (rst_n) begin
      if (in_valid && !in_stall) begin
        pending_results = {pending_results, histogram_step(in_data)};
        in_beats++;
      end
      if (out_valid && !out_stall) begin
        out_beats++;
        if (pending_results.size() == 0) begin
          $error("unexpected result beat");
          failed = 1;
        end else begin
          e = pending_results.pop_front();
          if (out_data.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_data.status);
            failed = 1;
          end
          if (out_data.bin_value !== e.bin_value) begin
            $error("bin_value exp %0d got %0d", e.bin_value, out_data.bin_value);
            failed = 1;
          end
          if (out_data.found_bin !== e.found_bin) begin
            $error("found_bin exp %0d got %0d", e.found_bin, out_data.found_bin);
            failed = 1;
          end
          if (out_data.entry_count !== e.entry_count) begin
            $error("entry_count exp %0d got %0d", e.entry_count, out_data.entry_count);
            failed = 1;
          end
        end
      end
    end
  end

  // receiver stall per result beat
  initial begin
    int k;
    int unsigned c;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      k = calm ? 0 : $urandom_range(0, 12);
      @(negedge clk);
      out_stall = (k > 0);
      repeat (k) @(negedge clk);
      out_stall = 1'b0;
      c = out_beats;
      while (out_beats == c) @(negedge clk);
    end
  end

  task automatic send_beat(in_item_t it);
    int g;
    int unsigned c;
    g = calm ? 0 : $urandom_range(0, 12);
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_data = it;
    in_valid = 1'b1;
    c = in_beats;
    do @(negedge clk); while (in_beats == c);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      CFG_BIN_MODE: mode_tab = val[0];
      CFG_LOW_EDGE: low_e = longint'($signed(val));
      CFG_BIN_WIDTH: width_r = val[30:0];
      CFG_BIN_COUNT: count_r = val[8:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic in_item_t beat(logic [CMD_W-1:0] c, longint x, longint xu,
                                    int w, int idx);
    in_item_t it;
    it.cmd = c;
    it.x = x[31:0];
    it.x_upper = xu[31:0];
    it.weight = w[15:0];
    it.bin_index = idx[8:0];
    return it;
  endfunction

  function automatic longint clamp_x(longint v);
    if (v < XMIN) return XMIN;
    if (v > XMAX) return XMAX;
    return v;
  endfunction

  function automatic longint pick_x(longint a, longint b);
    longint unsigned r;
    if ($urandom_range(0, 4) == 0) return longint'($signed($urandom));
    if (b <= a) return clamp_x(a);
    r = {$urandom, $urandom};
    return clamp_x(a + longint'(r % longint'(b - a + 1)));
  endfunction

  // random beat; most hit the span [a, b], ranges usually a few bins wide
  function automatic in_item_t random_beat(longint a, longint b, longint stride);
    int p;
    longint x, xu;
    logic [CMD_W-1:0] c;
    p = $urandom_range(0, 99);
    if (p < 40) c = CMD_FILL_PT;
    else if (p < 70) c = CMD_FILL_RG;
    else if (p < 86) c = CMD_READ;
    else if (p < 89) c = CMD_CLEAR;
    else if (p < 95) c = CMD_APPEND;
    else c = CMD_W'($urandom_range(5, 7));
    x = pick_x(a, b);
    if ($urandom_range(0, 32) == 0) xu = longint'($signed($urandom));
    else xu = clamp_x(x + longint'($urandom_range(0, 1 << 20)) % (4 * stride + 1)
                        - (($urandom_range(0, 3) == 0) ? 2 * stride : 0));
    return beat(c, x, xu, $urandom_range(0, 65535), $urandom_range(0, 511));
  endfunction

  task automatic test_uniform_directed();
    send_beat(beat(CMD_FILL_PT, XMIN, 0, 65535, 0));
    send_beat(beat(CMD_FILL_PT, 0, 0, 0, 0));
    send_beat(beat(CMD_FILL_PT, 65535, 0, 256, 0));
    send_beat(beat(CMD_FILL_PT, 255 * 65536, 0, 1, 0));
    send_beat(beat(CMD_FILL_PT, 256 * 65536, 0, 65535, 0));
    send_beat(beat(CMD_FILL_PT, XMAX, 0, 65535, 0));
    send_beat(beat(CMD_FILL_RG, 100, 200, 65535, 0));
    send_beat(beat(CMD_FILL_RG, 5 * 65536 + 7, 32768, 300, 0));
    send_beat(beat(CMD_FILL_RG, -65536, 3 * 65536 + 1, 65535, 0));
    send_beat(beat(CMD_FILL_RG, 254 * 65536, 258 * 65536, 4096, 0));
    send_beat(beat(CMD_READ, 0, 0, 0, 0));
    send_beat(beat(CMD_READ, 0, 0, 0, 1));
    send_beat(beat(CMD_READ, 0, 0, 0, 6));
    send_beat(beat(CMD_READ, 0, 0, 0, 257));
    send_beat(beat(CMD_READ, 0, 0, 0, 511));
    send_beat(beat(3'd5, XMAX, XMIN, 65535, 511));
    send_beat(beat(3'd6, 0, 0, 0, 0));
    send_beat(beat(3'd7, 0, 0, 0, 0));
    send_beat(beat(CMD_CLEAR, 0, 0, 0, 0));
    send_beat(beat(CMD_READ, 0, 0, 0, 1));
    send_beat(beat(CMD_READ, 0, 0, 0, 0));
  endtask

  task automatic run_uniform(longint lo, longint unsigned w, int unsigned cnt, int items);
    longint ww, a, b;
    write_reg(CFG_BIN_MODE, 0);
    write_reg(CFG_LOW_EDGE, lo[31:0]);
    write_reg(CFG_BIN_WIDTH, w[31:0]);
    write_reg(CFG_BIN_COUNT, cnt);
    ww = uni_w();
    a = clamp_x(low_e - ww);
    b = clamp_x(low_e + longint'(bins_in_use() + 1) * ww);
    repeat (items) send_beat(random_beat(a, b, ww));
  endtask

  task automatic test_uniform_settings();
    run_uniform(0, 65536, 256, 150);
    run_uniform(XMIN, 1, 1, 120);
    calm = 1;
    run_uniform(longint'($signed($urandom)) >>> 4, 0, 0, 120);
    calm = 0;
    run_uniform(XMIN + 1000, 31'h7FFF_FFFF, 511, 120);
    run_uniform(longint'($signed($urandom)) >>> 3, $urandom_range(1, 1 << 18),
                $urandom_range(1, 300), 200);
    run_uniform(-12345, 4096, 256, 150);
  endtask

  task automatic table_items(int items, longint stride);
    repeat (items) send_beat(random_beat(edges[0] - stride, edges[n_edges - 1] + stride,
                                         stride));
  endtask

  task automatic test_table_small();
    write_reg(CFG_BIN_MODE, 1);
    send_beat(beat(CMD_FILL_PT, 65536, 0, 500, 0));
    send_beat(beat(CMD_FILL_RG, XMIN, XMAX, 700, 0));
    send_beat(beat(CMD_READ, 0, 0, 0, 0));
    send_beat(beat(CMD_READ, 0, 0, 0, 300));
    send_beat(beat(CMD_APPEND, 0, 0, 0, 0));
    send_beat(beat(CMD_FILL_PT, 0, 0, 1000, 0));
    send_beat(beat(CMD_FILL_PT, 65536, 0, 1000, 0));
    send_beat(beat(CMD_FILL_RG, -10, 70000, 1000, 0));
    send_beat(beat(CMD_READ, 0, 0, 0, 1));
    send_beat(beat(CMD_READ, 0, 0, 0, 2));
    send_beat(beat(CMD_APPEND, 0, 0, 0, 0));
    send_beat(beat(CMD_APPEND, -5, 0, 0, 0));
    send_beat(beat(CMD_APPEND, 1, 0, 0, 0));
    send_beat(beat(CMD_APPEND, 65536, 0, 0, 0));
    table_items(150, 65536);
  endtask

  task automatic test_table_fill();
    longint step;
    calm = 1;
    while (n_edges < NEDGE && edges[n_edges - 1] < XMAX) begin
      calm = (n_edges > 120) ? 0 : calm;
      step = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(1, 1 << 20);
      if (step > XMAX - edges[n_edges - 1]) step = XMAX - edges[n_edges - 1];
      if ($urandom_range(0, 1) == 0)
        send_beat(beat(CMD_APPEND, edges[n_edges - 1] + step, 0, 0, 0));
      else
        table_items(1, 1 << 19);
    end
    calm = 0;
    send_beat(beat(CMD_APPEND, XMAX, 0, 0, 0));
    send_beat(beat(CMD_APPEND, XMIN, 0, 0, 0));
    table_items(300, 1 << 19);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    failed = 0;
    calm = 0;
    in_beats = 0;
    out_beats = 0;
    cycles = 0;
    foreach (sums[i]) sums[i] = 0;
    foreach (edges[i]) edges[i] = 0;
    n_edges = 0;
    fills = 0;
    mode_tab = 0;
    low_e = 0;
    width_r = 65536;
    count_r = 256;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_uniform_directed();
    test_uniform_settings();
    test_table_small();
    test_table_fill();
    run_uniform(-65536 * 3, 65536, 256, 150);
    drain();
    repeat (100) @(negedge clk);
    if (!failed && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
sv/whe_pkg.sv
sv/whe_front.sv
sv/whe_queue.sv
sv/whe_div.sv
sv/whe_back.sv
sv/weighted_histogram_engine.sv
bench/tb.sv
